FILE: design/dcr_pkg.sv
// ----------------------------------------------------------------------------
// dcr_pkg
// Shared constants and types of the density color ramp: stop register
// layout, reset contents of the stops and the color pair that rides along
// with an item through the divider.
// ----------------------------------------------------------------------------
package dcr_pkg;

   localparam int NUM_STOPS          = 5;
   localparam int STOP_BITS          = 56;
   localparam int COLOR_BITS         = 32;
   localparam int LEVEL_LSB          = 32;
   localparam int LEVEL_FIELD_BITS   = 24;
   localparam int DENSITY_FIELD_BITS = 24;
   localparam int MAX_DENSITY_BITS   = 32;
   localparam int CHANNEL_BITS       = 8;
   localparam int NUM_CHANNELS       = 4;
   localparam int CSR_INDEX_BITS     = 3;

   // Index of the first stop register; the stops follow in order.
   localparam int CSR_STOP_BASE      = 0;

   localparam int DEF_DENSITY_BITS   = 24;
   localparam int DEF_WEIGHT_BITS    = 8;

   typedef logic [STOP_BITS-1:0]  stop_type;
   typedef logic [COLOR_BITS-1:0] color_type;

   localparam stop_type STOP_RESET [NUM_STOPS] = '{
      56'h0000000080FF0000,
      56'h0000064080FFFF00,
      56'h00000C808000FF00,
      56'h00001F408000FFFF,
      56'h00003E80800000FF
   };

   typedef struct packed {
      color_type from_color;
      color_type to_color;
   } color_pair_type;

endpackage

FILE: design/dcr_div.sv
// ----------------------------------------------------------------------------
// dcr_div
// Pipelined restoring divider that forms the blend weight, one quotient bit
// per stage, with the color pair carried alongside each item.
// ----------------------------------------------------------------------------
module dcr_div #(
   parameter int DENSITY_BITS = dcr_pkg::DEF_DENSITY_BITS,
   parameter int WEIGHT_BITS  = dcr_pkg::DEF_WEIGHT_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     enable,
   input  logic                     in_valid,
   input  logic [DENSITY_BITS-1:0]  in_num,
   input  logic [DENSITY_BITS-1:0]  in_den,
   input  dcr_pkg::color_pair_type  in_pair,
   output logic                     out_valid,
   output logic [WEIGHT_BITS-1:0]   out_quot,
   output dcr_pkg::color_pair_type  out_pair
);
   import dcr_pkg::*;

   // The numerator is always below the divisor, so the remainder stays below
   // the divisor and the quotient fits in WEIGHT_BITS bits.
   logic                    valid_ff [WEIGHT_BITS];
   logic [DENSITY_BITS-1:0] rem_ff   [WEIGHT_BITS];
   logic [DENSITY_BITS-1:0] den_ff   [WEIGHT_BITS];
   logic [WEIGHT_BITS-1:0]  quot_ff  [WEIGHT_BITS];
   color_pair_type          pair_ff  [WEIGHT_BITS];

   for (genvar k = 0; k < WEIGHT_BITS; k++) begin : g_step
      logic                    valid_prev;
      logic [DENSITY_BITS-1:0] rem_prev;
      logic [DENSITY_BITS-1:0] den_prev;
      logic [WEIGHT_BITS-1:0]  quot_prev;
      color_pair_type          pair_prev;
      logic [DENSITY_BITS:0]   shifted;
      logic [DENSITY_BITS:0]   diff;
      logic                    quot_bit;

      if (k == 0) begin : g_first
         assign valid_prev = in_valid;
         assign rem_prev   = in_num;
         assign den_prev   = in_den;
         assign quot_prev  = '0;
         assign pair_prev  = in_pair;
      end else begin : g_next
         assign valid_prev = valid_ff[k-1];
         assign rem_prev   = rem_ff[k-1];
         assign den_prev   = den_ff[k-1];
         assign quot_prev  = quot_ff[k-1];
         assign pair_prev  = pair_ff[k-1];
      end

      assign shifted  = {rem_prev, 1'b0};
      assign diff     = shifted - {1'b0, den_prev};
      assign quot_bit = (shifted >= {1'b0, den_prev});

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (enable) begin
            valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k]  <= quot_bit ? diff[DENSITY_BITS-1:0] : shifted[DENSITY_BITS-1:0];
            den_ff[k]  <= den_prev;
            quot_ff[k] <= {quot_prev[WEIGHT_BITS-2:0], quot_bit};
            pair_ff[k] <= pair_prev;
         end
      end
   end

   assign out_valid = valid_ff[WEIGHT_BITS-1];
   assign out_quot  = quot_ff[WEIGHT_BITS-1];
   assign out_pair  = pair_ff[WEIGHT_BITS-1];

endmodule

FILE: design/density_color_ramp.sv
// ----------------------------------------------------------------------------
// density_color_ramp
// Maps a texel density to an ARGB color through a five-stop linear ramp.
// ----------------------------------------------------------------------------
// The block takes one density item per clock while the result side does not
// stall, and returns one ARGB color item for each, in order. Its depth is set
// mostly by the weight divider, which produces one quotient bit per pipeline
// stage; around it sit a compare stage, a segment select stage and a blend
// stage that drives the output registers. The whole pipeline holds while a
// finished color waits on a stalled result channel, and runs freely whenever
// the output register is empty or being taken. The user must write the five
// stops through the csr port only while no item is in flight; the block does
// not enforce this. Each stop holds a level in bits 55..32 (unsigned 20.4) and
// an ARGB color in bits 31..0. Stops are expected in ascending order.
// ----------------------------------------------------------------------------
module density_color_ramp #(
   parameter int DENSITY_BITS = dcr_pkg::DEF_DENSITY_BITS,
   parameter int WEIGHT_BITS  = dcr_pkg::DEF_WEIGHT_BITS
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic [dcr_pkg::DENSITY_FIELD_BITS-1:0]    req_density,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic [dcr_pkg::CHANNEL_BITS-1:0]          rsp_alpha,
   output logic [dcr_pkg::CHANNEL_BITS-1:0]          rsp_red,
   output logic [dcr_pkg::CHANNEL_BITS-1:0]          rsp_green,
   output logic [dcr_pkg::CHANNEL_BITS-1:0]          rsp_blue,
   input  logic                                      csr_write,
   input  logic [dcr_pkg::CSR_INDEX_BITS-1:0]        csr_index,
   input  logic [dcr_pkg::STOP_BITS-1:0]             csr_data
);
   import dcr_pkg::*;

   localparam int SUM_BITS = CHANNEL_BITS + WEIGHT_BITS + 2;
   localparam logic [WEIGHT_BITS:0] WEIGHT_ONE = (WEIGHT_BITS + 1)'(1) << WEIGHT_BITS;

   // Stop registers and the levels and colors taken from them.
   stop_type                stop_ff [NUM_STOPS];
   logic [DENSITY_BITS-1:0] level   [NUM_STOPS];
   color_type               color   [NUM_STOPS];
   logic [MAX_DENSITY_BITS-1:0] level_wide [NUM_STOPS];
   logic [MAX_DENSITY_BITS-1:0] density_wide;

   // Global advance: every stage moves when the output register can take
   // a new value.
   logic en;

   // Stage A: density and its compares against every level.
   logic                    valid_a_ff;
   logic [DENSITY_BITS-1:0] d_a_ff;
   logic [NUM_STOPS-1:0]    ge_a_ff;
   logic [NUM_STOPS-1:0]    ge_a_in;

   // Stage B: chosen segment as numerator, divisor and color pair.
   logic                    valid_b_ff;
   logic [DENSITY_BITS-1:0] num_b_ff;
   logic [DENSITY_BITS-1:0] num_b_in;
   logic [DENSITY_BITS-1:0] den_b_ff;
   logic [DENSITY_BITS-1:0] den_b_in;
   color_pair_type          pair_b_ff;
   color_pair_type          pair_b_in;
   logic                    seg_found;
   logic [DENSITY_BITS-1:0] lo_sel;
   logic [DENSITY_BITS-1:0] hi_sel;

   // Divider output.
   logic                    valid_w;
   logic [WEIGHT_BITS-1:0]  weight_w;
   color_pair_type          pair_w;

   // Output stage.
   logic                    rsp_valid_ff;
   logic [CHANNEL_BITS-1:0] chan_ff [NUM_CHANNELS];
   logic [CHANNEL_BITS-1:0] chan_in [NUM_CHANNELS];
   logic [WEIGHT_BITS:0]    inv_weight;

   // ------------------------------------------------------------------------
   // Configuration. Writes to an index past the last stop are dropped.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_STOPS; i++) begin
            stop_ff[i] <= STOP_RESET[i];
         end
      end else if (csr_write) begin
         for (int i = 0; i < NUM_STOPS; i++) begin
            if (csr_index == CSR_INDEX_BITS'(CSR_STOP_BASE + i)) begin
               stop_ff[i] <= csr_data;
            end
         end
      end
   end

   // Only the low DENSITY_BITS bits of a level or a density take part.
   always_comb begin
      for (int i = 0; i < NUM_STOPS; i++) begin
         level_wide[i] = MAX_DENSITY_BITS'(stop_ff[i][LEVEL_LSB +: LEVEL_FIELD_BITS]);
         level[i]      = level_wide[i][DENSITY_BITS-1:0];
         color[i]      = stop_ff[i][COLOR_BITS-1:0];
      end
   end

   assign density_wide = MAX_DENSITY_BITS'(req_density);

   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;

   // ------------------------------------------------------------------------
   // Stage A: compare the density against every stop level in parallel.
   // ------------------------------------------------------------------------
   always_comb begin
      for (int i = 0; i < NUM_STOPS; i++) begin
         ge_a_in[i] = (density_wide[DENSITY_BITS-1:0] >= level[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else if (en) begin
         valid_a_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_a_ff  <= density_wide[DENSITY_BITS-1:0];
         ge_a_ff <= ge_a_in;
      end
   end

   // ------------------------------------------------------------------------
   // Stage B: pick the segment. Below the first stop and at or above the last
   // stop the color is flat; a flat color is sent through the divider as
   // zero over one, so its weight comes out as zero. When unsorted stops
   // leave no matching segment, the last color is used.
   // ------------------------------------------------------------------------
   always_comb begin
      seg_found = 1'b0;
      lo_sel    = '0;
      hi_sel    = '0;
      pair_b_in.from_color = color[NUM_STOPS-1];
      pair_b_in.to_color   = color[NUM_STOPS-1];
      num_b_in  = '0;
      den_b_in  = DENSITY_BITS'(1);
      if (!ge_a_ff[0]) begin
         pair_b_in.from_color = color[0];
         pair_b_in.to_color   = color[0];
      end else if (!ge_a_ff[NUM_STOPS-1]) begin
         for (int i = 0; i < NUM_STOPS - 1; i++) begin
            if (!seg_found && ge_a_ff[i] && !ge_a_ff[i+1]) begin
               seg_found            = 1'b1;
               lo_sel               = level[i];
               hi_sel               = level[i+1];
               pair_b_in.from_color = color[i];
               pair_b_in.to_color   = color[i+1];
            end
         end
         if (seg_found) begin
            num_b_in = d_a_ff - lo_sel;
            den_b_in = hi_sel - lo_sel;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_b_ff <= 1'b0;
      end else if (en) begin
         valid_b_ff <= valid_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_b_ff  <= num_b_in;
         den_b_ff  <= den_b_in;
         pair_b_ff <= pair_b_in;
      end
   end

   // ------------------------------------------------------------------------
   // Weight: (density - lower) * 2^WEIGHT_BITS / (upper - lower), truncated.
   // ------------------------------------------------------------------------
   dcr_div #(
      .DENSITY_BITS (DENSITY_BITS),
      .WEIGHT_BITS  (WEIGHT_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (en),
      .in_valid  (valid_b_ff),
      .in_num    (num_b_ff),
      .in_den    (den_b_ff),
      .in_pair   (pair_b_ff),
      .out_valid (valid_w),
      .out_quot  (weight_w),
      .out_pair  (pair_w)
   );

   // ------------------------------------------------------------------------
   // Blend stage: each channel is from * (1 - w) + to * w, truncated.
   // ------------------------------------------------------------------------
   assign inv_weight = WEIGHT_ONE - {1'b0, weight_w};

   always_comb begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         logic [SUM_BITS-1:0] sum;
         sum = SUM_BITS'(pair_w.from_color[c*CHANNEL_BITS +: CHANNEL_BITS])
                  * SUM_BITS'(inv_weight)
               + SUM_BITS'(pair_w.to_color[c*CHANNEL_BITS +: CHANNEL_BITS])
                  * SUM_BITS'(weight_w);
         chan_in[c] = sum[WEIGHT_BITS +: CHANNEL_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= valid_w;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            chan_ff[c] <= chan_in[c];
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_alpha = chan_ff[3];
   assign rsp_red   = chan_ff[2];
   assign rsp_green = chan_ff[1];
   assign rsp_blue  = chan_ff[0];

   // ------------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------------

   // An empty output register never holds back the input side.
   a_no_stall_when_empty : assert property (
      @(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> !req_stall
   ) else $error("input stalled while the output register is empty");

   // The selected segment never hands the divider a zero divisor.
   a_den_nonzero : assert property (
      @(posedge clock) disable iff (reset)
      valid_b_ff |-> (den_b_ff != '0)
   ) else $error("zero divisor entered the weight divider");

   // A density at or above the last stop yields a flat color.
   a_top_flat : assert property (
      @(posedge clock) disable iff (reset)
      (valid_a_ff && en && ge_a_ff[NUM_STOPS-1]) |=>
         (pair_b_ff.from_color == pair_b_ff.to_color && num_b_ff == '0)
   ) else $error("saturated density did not select a flat color");

endmodule

FILE: test/ramp_check_pkg.sv
// ----------------------------------------------------------------------------
// ramp_check_pkg
// Scoreboard for the density color ramp: keeps a copy of the five stops,
// works out the expected ARGB color of each accepted density and compares
// every returned color with the oldest one still outstanding.
// ----------------------------------------------------------------------------
package ramp_check_pkg;

   import dcr_pkg::*;

   localparam int WEIGHT_SHIFT = DEF_WEIGHT_BITS;

   typedef logic [DENSITY_FIELD_BITS-1:0] density_type;
   typedef logic [LEVEL_FIELD_BITS-1:0]   level_type;

   typedef struct packed {
      logic [CHANNEL_BITS-1:0] alpha;
      logic [CHANNEL_BITS-1:0] red;
      logic [CHANNEL_BITS-1:0] green;
      logic [CHANNEL_BITS-1:0] blue;
   } argb_type;

   class ramp_scoreboard;
      stop_type stop_reg [NUM_STOPS];
      argb_type color_q [$];
      int       errors;

      function new();
         foreach (stop_reg[i]) stop_reg[i] = STOP_RESET[i];
         errors = 0;
      endfunction

      // Writes to indexes past the last stop leave the ramp unchanged.
      function void write_stop(int index, stop_type value);
         if (index >= CSR_STOP_BASE && index < CSR_STOP_BASE + NUM_STOPS)
            stop_reg[index - CSR_STOP_BASE] = value;
      endfunction

      function level_type level_of_stop(int i);
         return stop_reg[i][LEVEL_LSB +: LEVEL_FIELD_BITS];
      endfunction

      function argb_type ramp_color(density_type d);
         color_type   from_c;
         color_type   to_c;
         level_type   lo;
         level_type   hi;
         logic [31:0] scaled;
         int unsigned w;
         int unsigned mix;
         bit          found;
         argb_type    c;
         w      = 0;
         found  = 1'b0;
         from_c = stop_reg[NUM_STOPS-1][COLOR_BITS-1:0];
         to_c   = from_c;
         if (d < level_of_stop(0)) begin
            from_c = stop_reg[0][COLOR_BITS-1:0];
            to_c   = from_c;
         end else if (d < level_of_stop(NUM_STOPS-1)) begin
            // The first segment that brackets the density wins, sorted or not.
            for (int i = 0; i < NUM_STOPS - 1; i++) begin
               lo = level_of_stop(i);
               hi = level_of_stop(i + 1);
               if (!found && d >= lo && d < hi) begin
                  found  = 1'b1;
                  scaled = 32'(d - lo);
                  scaled = scaled << WEIGHT_SHIFT;
                  w      = scaled / 32'(hi - lo);
                  from_c = stop_reg[i][COLOR_BITS-1:0];
                  to_c   = stop_reg[i+1][COLOR_BITS-1:0];
               end
            end
         end
         for (int k = 0; k < NUM_CHANNELS; k++) begin
            mix = 32'(from_c[CHANNEL_BITS*k +: CHANNEL_BITS]) * ((1 << WEIGHT_SHIFT) - w)
                + 32'(to_c[CHANNEL_BITS*k +: CHANNEL_BITS]) * w;
            c[CHANNEL_BITS*k +: CHANNEL_BITS] = CHANNEL_BITS'(mix >> WEIGHT_SHIFT);
         end
         return c;
      endfunction

      function void note_density(density_type d);
         color_q = {color_q, ramp_color(d)};
      endfunction

      function int pending();
         return color_q.size();
      endfunction

      task report(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_color(argb_type got);
         argb_type want;
         string    channel_name [NUM_CHANNELS] = '{"blue", "green", "red", "alpha"};
         if (color_q.size() == 0) begin
            report($sformatf("color %h returned with nothing outstanding", got));
         end else begin
            want = color_q.pop_front();
            for (int k = 0; k < NUM_CHANNELS; k++) begin
               if (got[CHANNEL_BITS*k +: CHANNEL_BITS] != want[CHANNEL_BITS*k +: CHANNEL_BITS])
                  report($sformatf("%s is %h, expected %h (color %h, expected %h)",
                                   channel_name[k], got[CHANNEL_BITS*k +: CHANNEL_BITS],
                                   want[CHANNEL_BITS*k +: CHANNEL_BITS], got, want));
            end
         end
      endtask
   endclass

endpackage

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives densities into the color ramp under random bursts and result-side
// stalls, reprograms the five stops between phases, and checks every color
// against a scoreboard that follows the stop registers.
// ----------------------------------------------------------------------------
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   import dcr_pkg::*;
   import ramp_check_pkg::*;

   typedef enum {SHAPE_WIDE, SHAPE_NARROW, SHAPE_LOW, SHAPE_UNSORTED, SHAPE_TIED}
      ramp_shape_type;
   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_pattern_type;

   // The divider sets the depth: one stage per weight bit plus three more.
   localparam int PIPE_DEPTH  = DEF_WEIGHT_BITS + 3;
   localparam int HOLD_CYCLES = 120;
   localparam int PHASE_ITEMS = 100;
   localparam int HOLD_ITEMS  = 150;
   localparam int NUM_PHASES  = 12;
   localparam int HOLD_PHASE  = 3;
   localparam int RESET_PHASE = 6;

   logic                       clock       = 1'b0;
   logic                       reset       = 1'b1;
   logic                       req_valid   = 1'b0;
   logic                       req_stall;
   density_type                req_density = '0;
   logic                       rsp_valid;
   logic                       rsp_stall   = 1'b0;
   logic [CHANNEL_BITS-1:0]    rsp_alpha;
   logic [CHANNEL_BITS-1:0]    rsp_red;
   logic [CHANNEL_BITS-1:0]    rsp_green;
   logic [CHANNEL_BITS-1:0]    rsp_blue;
   logic                       csr_write   = 1'b0;
   logic [CSR_INDEX_BITS-1:0]  csr_index   = '0;
   stop_type                   csr_data    = '0;

   ramp_scoreboard sb;

   // Raised by the stimulus to ask the receiver for one long hold-off.
   logic hold_request = 1'b0;

   always #4 clock = ~clock;

   density_color_ramp u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_density (req_density),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_alpha   (rsp_alpha),
      .rsp_red     (rsp_red),
      .rsp_green   (rsp_green),
      .rsp_blue    (rsp_blue),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   // Every color taken at a rising edge is checked against the oldest
   // expectation. Outputs are read before the edge's updates land.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_color({rsp_alpha, rsp_red, rsp_green, rsp_blue});
   end

   // The receiver switches between stall patterns of random length. When a
   // hold-off is requested it stalls solidly for a stretch far longer than the
   // pipeline is deep, so the block has to stall its input.
   initial begin : receiver
      stall_pattern_type pattern;
      int                span;
      forever begin
         pattern = stall_pattern_type'($urandom_range(0, 3));
         span    = $urandom_range(8, 80);
         if (hold_request) begin
            repeat (HOLD_CYCLES) begin
               @(negedge clock);
               rsp_stall = 1'b1;
            end
            hold_request = 1'b0;
         end else begin
            for (int c = 0; c < span && !hold_request; c++) begin
               @(negedge clock);
               case (pattern)
                  STALL_NONE:   rsp_stall = 1'b0;
                  STALL_LIGHT:  rsp_stall = ($urandom_range(0, 3) == 0);
                  STALL_HEAVY:  rsp_stall = ($urandom_range(0, 3) != 0);
                  STALL_TOGGLE: rsp_stall = ~rsp_stall;
                  default:      rsp_stall = 1'b0;
               endcase
            end
         end
      end
   end

   // Offers one density and returns at the edge where it is taken. The valid
   // is left high so that back-to-back items keep it up without a dip.
   task automatic send_density(density_type d);
      @(negedge clock);
      req_valid   = 1'b1;
      req_density = d;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_density(d);
   endtask

   // Idle cycles on the input side. The density wiggles to show that the
   // block ignores it while valid is low.
   task automatic pause_sender(int n);
      repeat (n) begin
         @(negedge clock);
         req_valid   = 1'b0;
         req_density = density_type'($urandom);
         @(posedge clock);
      end
   endtask

   // Stops offering items and waits until every expected color is back, so
   // that the stops may be rewritten safely.
   task automatic drain_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_csr(int index, stop_type data);
      @(negedge clock);
      csr_write = 1'b1;
      csr_index = CSR_INDEX_BITS'(index);
      csr_data  = data;
      @(posedge clock);
      sb.write_stop(index, data);
      @(negedge clock);
      csr_write = 1'b0;
   endtask

   task automatic write_ramp(level_type lv [NUM_STOPS], color_type col [NUM_STOPS]);
      for (int i = 0; i < NUM_STOPS; i++)
         write_csr(CSR_STOP_BASE + i, {lv[i], col[i]});
   endtask

   // Builds a random ramp. Narrow ramps have steps of a few LSBs so that the
   // weight hits its ends; tied ramps repeat one level to give an empty
   // segment; unsorted ramps exercise the first-match rule.
   task automatic load_random_ramp(ramp_shape_type shape);
      level_type lv  [NUM_STOPS];
      color_type col [NUM_STOPS];
      level_type t;
      int        k;
      for (int i = 0; i < NUM_STOPS; i++) begin
         case (shape)
            SHAPE_NARROW: begin
               if (i == 0)
                  lv[i] = level_type'($urandom_range(0, 24'hFFFF00));
               else
                  lv[i] = level_type'(lv[i-1] + $urandom_range(1, 6));
            end
            SHAPE_LOW: lv[i] = level_type'($urandom_range(0, 4000));
            default:   lv[i] = level_type'($urandom);
         endcase
         case ($urandom_range(0, 5))
            0:       col[i] = '0;
            1:       col[i] = '1;
            default: col[i] = $urandom;
         endcase
      end
      if (shape != SHAPE_UNSORTED) begin
         for (int a = 0; a < NUM_STOPS - 1; a++) begin
            for (int b = 0; b < NUM_STOPS - 1 - a; b++) begin
               if (lv[b] > lv[b+1]) begin
                  t       = lv[b];
                  lv[b]   = lv[b+1];
                  lv[b+1] = t;
               end
            end
         end
      end
      if (shape == SHAPE_TIED) begin
         k       = $urandom_range(0, NUM_STOPS - 2);
         lv[k+1] = lv[k];
      end
      write_ramp(lv, col);
   endtask

   // Most densities land inside a segment of the current ramp; some sit on
   // or next to a stop level, and the rest cover the whole field.
   function automatic density_type pick_density();
      int          seg;
      level_type   lo;
      level_type   hi;
      int unsigned r;
      r   = $urandom_range(0, 99);
      seg = $urandom_range(0, NUM_STOPS - 2);
      lo  = sb.level_of_stop(seg);
      hi  = sb.level_of_stop(seg + 1);
      if (r < 15)
         return density_type'($urandom);
      else if (r < 35)
         return density_type'(sb.level_of_stop($urandom_range(0, NUM_STOPS - 1))
                              + $urandom_range(0, 2) - 1);
      else if (hi > lo)
         return density_type'(lo + $urandom_range(0, hi - lo - 1));
      else
         return density_type'($urandom);
   endfunction

   // Sends items in bursts of random length. A steady phase never idles the
   // input, which gives stretches at full rate.
   task automatic run_phase(int count, bit steady);
      int left;
      int burst;
      left = count;
      while (left > 0) begin
         burst = $urandom_range(1, 24);
         while (burst > 0 && left > 0) begin
            send_density(pick_density());
            burst--;
            left--;
         end
         if (!steady && $urandom_range(0, 9) >= 3)
            pause_sender($urandom_range(1, 6));
      end
   endtask

   initial begin : stimulus
      level_type   lv  [NUM_STOPS];
      color_type   col [NUM_STOPS];
      density_type reset_probe [13] = '{
         24'h000000, 24'h000001, 24'h00063F, 24'h000640, 24'h000641,
         24'h000960, 24'h000C80, 24'h001F3F, 24'h001F40, 24'h003E7F,
         24'h003E80, 24'hFFFFFF, 24'h7FFFFF
      };
      sb = new();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // The reset ramp: each stop level, a density one LSB below or above most of
      // them, a point inside a segment, and the middle and top of the density range.
      foreach (reset_probe[i]) send_density(reset_probe[i]);
      drain_results();

      // Indexes past the last stop must not disturb the ramp.
      for (int idx = CSR_STOP_BASE + NUM_STOPS; idx < (1 << CSR_INDEX_BITS); idx++)
         write_csr(idx, stop_type'({$urandom, $urandom}));
      send_density(24'h000320);
      send_density(24'h002EE0);
      drain_results();

      // Extreme ramp: a single segment spanning the whole density field from
      // black to white, with the remaining stops piled at the top.
      lv  = '{24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF};
      col = '{32'h00000000, 32'hFFFFFFFF, 32'h00000000, 32'h00000000, 32'h5AA5C33C};
      write_ramp(lv, col);
      send_density(24'h000000);
      send_density(24'h7FFFFF);
      send_density(24'hFFFFFE);
      send_density(24'hFFFFFF);
      drain_results();

      // Unsorted stops: a density below the first level, one where two
      // segments overlap so the first one must win, and one that only the
      // last segment brackets.
      lv  = '{24'd4000, 24'd12000, 24'd2000, 24'd8000, 24'd16000};
      col = '{32'h80FF0000, 32'h80FFFF00, 32'h8000FF00, 32'h8000FFFF, 32'h800000FF};
      write_ramp(lv, col);
      send_density(24'd1000);
      send_density(24'd5000);
      send_density(24'd15000);
      drain_results();

      // Equal adjacent levels: the empty segments are skipped.
      lv  = '{24'd1600, 24'd1600, 24'd3200, 24'd3200, 24'd4800};
      col = '{32'hFF000000, 32'h00FF0000, 32'h0000FF00, 32'h000000FF, 32'hFFFFFFFF};
      write_ramp(lv, col);
      send_density(24'd1600);
      send_density(24'd2400);
      send_density(24'd3200);
      drain_results();

      // Random ramps. One phase returns to the reset contents, and one runs
      // the input flat out while the receiver holds off for a long time.
      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p == RESET_PHASE) begin
            for (int i = 0; i < NUM_STOPS; i++)
               write_csr(CSR_STOP_BASE + i, STOP_RESET[i]);
         end else begin
            load_random_ramp(ramp_shape_type'(p % 5));
         end
         if (p == HOLD_PHASE) begin
            hold_request = 1'b1;
            run_phase(HOLD_ITEMS, 1'b1);
         end else begin
            run_phase(PHASE_ITEMS, (p % 4) == 0);
         end
         drain_results();
      end

      // Leave room for any stray color the block might still emit.
      repeat (2 * PIPE_DEPTH) @(posedge clock);
      if (sb.errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // A correct run ends far sooner than this.
   initial begin : watchdog
      #2_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
